@@ rtl/xchj_pkg.sv @@
package xchj_pkg;

	localparam int ROW_W = 256;
	localparam int KEY_W = 64;
	localparam int KB_W = 7;
	localparam int NUM_W = 12;
	localparam int OUT_W = 288;

	localparam int VALUE_BITS_DEF = 256;
	localparam int MAX_ROWS_DEF = 4096;
	localparam int BUCKET_COUNT_DEF = 1024;
	localparam int BUCKET_SLOTS_DEF = 16;

	localparam logic [KB_W-1:0] KEY_BITS_RST = 7'd20;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_PROBE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [ROW_W-1:0] row;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic [KB_W-1:0] eff_kb(input logic [KB_W-1:0] kb);
		eff_kb = (kb > 7'd64) ? 7'd64 : kb;
	endfunction

	function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
		logic [KB_W-1:0] k;
		k = eff_kb(kb);
		key_mask = (k == 7'd64) ? {KEY_W{1'b1}} : ~({KEY_W{1'b1}} << k);
	endfunction

endpackage

@@ rtl/xor_collision_hash_join_top.sv @@
// One join round of a birthday collision search. Loads (tuser 0) store a left row and file it
// in the bucket of its low key_bits bits modulo BUCKET_COUNT, or set the overflow flag when the
// table or that bucket is full; probes (tuser 1) emit one transfer per stored left row of equal
// key, in load order, with the shifted XOR and both row numbers, tlast on the final match;
// clears (tuser 2) empty the table. Loads and probes are paced by the registered reads of the
// fill, slot and row memories in turn, and a probe also by any output stall. After reset and
// after each clear the bucket fill memory is swept, during which s_tready is low.
// A two-entry queue and an output register let input and output stall apart.
module xor_collision_hash_join_top #(
	parameter int VALUE_BITS = xchj_pkg::VALUE_BITS_DEF,
	parameter int MAX_ROWS = xchj_pkg::MAX_ROWS_DEF,
	parameter int BUCKET_COUNT = xchj_pkg::BUCKET_COUNT_DEF,
	parameter int BUCKET_SLOTS = xchj_pkg::BUCKET_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [xchj_pkg::KB_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [xchj_pkg::ROW_W-1:0] s_tdata, // row_word0, row_word1, row_word2, row_word3
	input  logic [1:0] s_tuser,                 // func
	output logic m_tvalid,
	input  logic m_tready,
	// joined_word0..joined_word3, left_row, right_row, overflowed, zero fill
	output logic [xchj_pkg::OUT_W-1:0] m_tdata,
	output logic m_tlast                        // last_match
);
	logic [xchj_pkg::KB_W-1:0] key_bits_q;
	logic q_push, q_full, q_pop, q_empty;
	xchj_pkg::cmd_t q_in, q_out;
	xchj_pkg::back_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_bits_q <= xchj_pkg::KEY_BITS_RST;
		else if (cfg_we) key_bits_q <= cfg_wdata;
	end

	xchj_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.key_bits(key_bits_q), .stat(stat), .q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	xchj_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_out)
	);

	xchj_back #(
		.VALUE_BITS(VALUE_BITS), .MAX_ROWS(MAX_ROWS),
		.BUCKET_COUNT(BUCKET_COUNT), .BUCKET_SLOTS(BUCKET_SLOTS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .key_bits(key_bits_q), .q_empty(q_empty),
		.q_data(q_out), .q_pop(q_pop), .stat(stat), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule

@@ rtl/xchj_ram.sv @@
module xchj_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0] wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/xchj_queue.sv @@
module xchj_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  xchj_pkg::cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output xchj_pkg::cmd_t pop_data
);
	xchj_pkg::cmd_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/xchj_front.sv @@
module xchj_front #(
	parameter int VALUE_BITS = xchj_pkg::VALUE_BITS_DEF
) (
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [xchj_pkg::ROW_W-1:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic [xchj_pkg::KB_W-1:0] key_bits,
	input  xchj_pkg::back_stat_t stat,
	input  logic q_full,
	output logic q_push,
	output xchj_pkg::cmd_t q_data
);
	logic [xchj_pkg::ROW_W-1:0] row;
	logic known;

	// bits above the value width are dropped here once
	assign row = s_tdata & ~({xchj_pkg::ROW_W{1'b1}} << VALUE_BITS);
	assign known = (s_tuser == xchj_pkg::FUNC_LOAD) || (s_tuser == xchj_pkg::FUNC_PROBE)
		|| (s_tuser == xchj_pkg::FUNC_CLEAR);

	assign s_tready = !q_full && !stat.clearing;
	assign q_push = s_tvalid && s_tready && known;

	always_comb begin
		q_data.func = s_tuser;
		q_data.row = row;
		q_data.key = row[xchj_pkg::KEY_W-1:0] & xchj_pkg::key_mask(key_bits);
	end
endmodule

@@ rtl/xchj_back.sv @@
module xchj_back #(
	parameter int VALUE_BITS = xchj_pkg::VALUE_BITS_DEF,
	parameter int MAX_ROWS = xchj_pkg::MAX_ROWS_DEF,
	parameter int BUCKET_COUNT = xchj_pkg::BUCKET_COUNT_DEF,
	parameter int BUCKET_SLOTS = xchj_pkg::BUCKET_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [xchj_pkg::KB_W-1:0] key_bits,
	input  logic q_empty,
	input  xchj_pkg::cmd_t q_data,
	output logic q_pop,
	output xchj_pkg::back_stat_t stat,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [xchj_pkg::OUT_W-1:0] m_tdata,
	output logic m_tlast
);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int FW = $clog2(BUCKET_SLOTS + 1);
	localparam int SD = BUCKET_COUNT * BUCKET_SLOTS;
	localparam int SW = (SD > 1) ? $clog2(SD) : 1;
	localparam int NW = xchj_pkg::NUM_W;

	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_DEC = 3'd3;
	localparam logic [2:0] ST_SLOT = 3'd4;
	localparam logic [2:0] ST_ROW = 3'd5;
	localparam logic [2:0] ST_MATCH = 3'd6;
	localparam logic [2:0] ST_FLUSH = 3'd7;

	logic [2:0] st_q;
	xchj_pkg::cmd_t cmd_q;
	logic [BW-1:0] bkt_q, clr_q;
	logic [FW-1:0] fill_q, idx_q;
	logic [CW-1:0] lcnt_q;
	logic [NW-1:0] rcnt_q, rnum_q;
	logic ovf_q;
	logic [RW-1:0] l_q;

	logic pend_v_q;
	logic [xchj_pkg::ROW_W-1:0] pend_d_q;
	logic [RW-1:0] pend_l_q;

	logic out_v_q, out_last_q, out_ovf_q;
	logic [xchj_pkg::ROW_W-1:0] out_d_q;
	logic [NW-1:0] out_l_q, out_r_q;

	logic fill_we, slot_we, row_we;
	logic [BW-1:0] fill_wa;
	logic [FW-1:0] fill_wd, fill_rd;
	logic [SW-1:0] slot_wa, slot_ra;
	logic [RW-1:0] slot_rd;
	logic [VALUE_BITS-1:0] row_rd;
	logic [BW-1:0] bkt_new;

	logic [xchj_pkg::ROW_W-1:0] lx, jx;
	logic hit, out_free, push_out, push_last;
	logic [xchj_pkg::ROW_W-1:0] push_d;
	logic [RW-1:0] push_l;

	assign bkt_new = BW'(q_data.key % BUCKET_COUNT);
	assign slot_ra = SW'(bkt_q) * SW'(BUCKET_SLOTS) + SW'(idx_q);

	assign fill_we = (st_q == ST_CLR) || (st_q == ST_DEC && cmd_q.func == xchj_pkg::FUNC_LOAD
		&& lcnt_q < CW'(MAX_ROWS) && fill_rd < FW'(BUCKET_SLOTS));
	assign slot_we = fill_we && st_q == ST_DEC;
	assign row_we = slot_we;
	assign fill_wa = (st_q == ST_CLR) ? clr_q : bkt_q;
	assign fill_wd = (st_q == ST_CLR) ? '0 : fill_rd + FW'(1);
	assign slot_wa = SW'(bkt_q) * SW'(BUCKET_SLOTS) + SW'(fill_rd);

	xchj_ram #(.W(FW), .D(BUCKET_COUNT)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_wa), .wdata(fill_wd),
		.raddr(bkt_q), .rdata(fill_rd)
	);
	xchj_ram #(.W(RW), .D(SD)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(lcnt_q[RW-1:0]),
		.raddr(slot_ra), .rdata(slot_rd)
	);
	xchj_ram #(.W(VALUE_BITS), .D(MAX_ROWS)) u_row (
		.clk(clk), .we(row_we), .waddr(lcnt_q[RW-1:0]),
		.wdata(cmd_q.row[VALUE_BITS-1:0]), .raddr(slot_rd), .rdata(row_rd)
	);

	assign lx = xchj_pkg::ROW_W'(row_rd);
	assign hit = (lx[xchj_pkg::KEY_W-1:0] & xchj_pkg::key_mask(key_bits)) == cmd_q.key;
	assign jx = (lx ^ cmd_q.row) >> xchj_pkg::eff_kb(key_bits);

	assign out_free = !out_v_q || m_tready;

	// a match is held in the pending register until the next match or the flush, so that the final one can be flagged
	always_comb begin
		push_out = 1'b0;
		push_last = 1'b0;
		push_d = pend_d_q;
		push_l = pend_l_q;
		if (st_q == ST_MATCH && hit && pend_v_q && out_free) begin
			push_out = 1'b1;
		end else if (st_q == ST_FLUSH && pend_v_q && out_free) begin
			push_out = 1'b1;
			push_last = 1'b1;
		end
	end

	assign q_pop = (st_q == ST_IDLE) && !q_empty;
	assign stat.clearing = (st_q == ST_CLR);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
			bkt_q <= bkt_new;
		end
		if (st_q == ST_DEC) fill_q <= fill_rd;
		if (st_q == ST_ROW) l_q <= slot_rd;
		if (st_q == ST_MATCH && hit && (!pend_v_q || out_free)) begin
			pend_d_q <= jx;
			pend_l_q <= l_q;
		end
		if (push_out) begin
			out_d_q <= push_d;
			out_l_q <= NW'(push_l);
			out_r_q <= rnum_q;
			out_last_q <= push_last;
			out_ovf_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			idx_q <= '0;
			lcnt_q <= '0;
			rcnt_q <= '0;
			rnum_q <= '0;
			ovf_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (push_out) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					lcnt_q <= '0;
					rcnt_q <= '0;
					ovf_q <= 1'b0;
					if (clr_q == BW'(BUCKET_COUNT - 1)) begin
						clr_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + BW'(1);
					end
				end
				ST_IDLE: begin
					if (!q_empty) st_q <= ST_FILL;
				end
				ST_FILL: begin
					st_q <= ST_DEC;
				end
				ST_DEC: begin
					idx_q <= '0;
					case (cmd_q.func)
						xchj_pkg::FUNC_LOAD: begin
							st_q <= ST_IDLE;
							if (fill_we) lcnt_q <= lcnt_q + CW'(1);
							else ovf_q <= 1'b1;
						end
						xchj_pkg::FUNC_PROBE: begin
							rnum_q <= rcnt_q;
							rcnt_q <= rcnt_q + NW'(1);
							st_q <= (fill_rd != '0) ? ST_SLOT : ST_IDLE;
						end
						xchj_pkg::FUNC_CLEAR: begin
							st_q <= ST_CLR;
						end
						default: begin
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_SLOT: begin
					st_q <= ST_ROW;
				end
				ST_ROW: begin
					st_q <= ST_MATCH;
				end
				ST_MATCH: begin
					if (!hit || !pend_v_q || out_free) begin
						if (hit) pend_v_q <= 1'b1;
						idx_q <= idx_q + FW'(1);
						st_q <= (idx_q + FW'(1) == fill_q) ? ST_FLUSH : ST_SLOT;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {7'd0, out_ovf_q, out_r_q, out_l_q, out_d_q};
endmodule

@@ rtl/xchj_checker.sv @@
module xchj_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tready,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [xchj_pkg::OUT_W-1:0] m_tdata,
	input  logic m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transfer withdrawn");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	// the table sweep follows reset, so nothing moves right after it
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid && !s_tready)
		else $error("activity right after reset");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[287:281] == 7'd0)
		else $error("output fill bits not zero");
endmodule

bind xor_collision_hash_join_top xchj_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

@@ tb/sv/tb.sv @@
module tb;

	typedef struct {
		logic [1:0] func;
		logic [xchj_pkg::ROW_W-1:0] row;
	} cmd_item_t;

	typedef struct {
		logic [xchj_pkg::ROW_W-1:0] joined;
		logic [xchj_pkg::NUM_W-1:0] lrow;
		logic [xchj_pkg::NUM_W-1:0] rrow;
		logic last;
		logic ovf;
	} join_t;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 1100;
	localparam logic [1:0] FUNC_RSVD = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [xchj_pkg::KB_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [xchj_pkg::ROW_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [xchj_pkg::OUT_W-1:0] m_tdata;
	logic m_tlast;

	cmd_item_t cmd_queue[$];
	join_t joins_due[$];
	logic [63:0] key_pool[$];

	// predictor copy of the table
	logic [xchj_pkg::ROW_W-1:0] stored_rows[xchj_pkg::MAX_ROWS_DEF];
	int bucket_fill[xchj_pkg::BUCKET_COUNT_DEF];
	int bucket_list[xchj_pkg::BUCKET_COUNT_DEF][xchj_pkg::BUCKET_SLOTS_DEF];
	int n_left;
	int n_right;
	logic ovf_flag;
	int kb;

	int errors;
	int s_gap;
	int m_gap;
	int idle_cycles;
	bit quiet;

	xor_collision_hash_join_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void join_predict(input logic [1:0] f,
		input logic [xchj_pkg::ROW_W-1:0] row);
		int k;
		int b;
		int l;
		int found;
		logic [63:0] m;
		logic [63:0] key;
		join_t j;
		k = (kb > 64) ? 64 : kb;
		m = (k == 64) ? {64{1'b1}} : ~({64{1'b1}} << k);
		key = row[63:0] & m;
		b = int'(key[9:0]);
		found = 0;
		case (f)
			xchj_pkg::FUNC_LOAD: begin
				if (n_left >= xchj_pkg::MAX_ROWS_DEF
					|| bucket_fill[b] >= xchj_pkg::BUCKET_SLOTS_DEF) begin
					ovf_flag = 1'b1;
				end else begin
					stored_rows[n_left] = row;
					bucket_list[b][bucket_fill[b]] = n_left;
					bucket_fill[b]++;
					n_left++;
				end
			end
			xchj_pkg::FUNC_PROBE: begin
				for (int i = 0; i < bucket_fill[b]; i++) begin
					l = bucket_list[b][i];
					if ((stored_rows[l][63:0] & m) == key) begin
						j.joined = (stored_rows[l] ^ row) >> k;
						j.lrow = l[xchj_pkg::NUM_W-1:0];
						j.rrow = n_right[xchj_pkg::NUM_W-1:0];
						j.last = 1'b0;
						j.ovf = ovf_flag;
						joins_due.insert(joins_due.size(), j);
						found++;
					end
				end
				if (found > 0) joins_due[joins_due.size()-1].last = 1'b1;
				n_right = (n_right + 1) % 4096;
			end
			xchj_pkg::FUNC_CLEAR: begin
				foreach (bucket_fill[i]) bucket_fill[i] = 0;
				n_left = 0;
				n_right = 0;
				ovf_flag = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [xchj_pkg::ROW_W-1:0] make_row(input logic [63:0] key);
		logic [xchj_pkg::ROW_W-1:0] r;
		int k;
		logic [63:0] m;
		k = (kb > 64) ? 64 : kb;
		m = (k == 64) ? {64{1'b1}} : ~({64{1'b1}} << k);
		for (int w = 0; w < 8; w++) r[w*32 +: 32] = $urandom;
		r[63:0] = (r[63:0] & ~m) | (key & m);
		return r;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic void push_cmd(input logic [1:0] f,
		input logic [xchj_pkg::ROW_W-1:0] row);
		cmd_item_t c;
		c.func = f;
		c.row = row;
		cmd_queue.insert(cmd_queue.size(), c);
	endfunction

	// driver: one transfer per accepted item, prediction at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= xchj_pkg::FUNC_LOAD;
			s_gap <= 0;
		end else begin
			cmd_item_t c;
			if (s_tvalid && s_tready) join_predict(s_tuser, s_tdata);
			if (!(s_tvalid && !s_tready)) begin
				if (s_gap > 0) begin
					s_gap <= s_gap - 1;
					s_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 19) == 0) begin
					s_gap <= $urandom_range(1, 18) - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= c.row;
					s_tuser <= c.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap <= 0;
		end else begin
			join_t e;
			if (m_tvalid && m_tready) begin
				if (joins_due.size() == 0) begin
					$display("%0t: unexpected transfer %h last %b", $time, m_tdata, m_tlast);
					errors++;
				end else begin
					e = joins_due.pop_front();
					if (m_tdata[255:0] !== e.joined) begin
						$display("%0t: joined exp %h got %h", $time, e.joined, m_tdata[255:0]);
						errors++;
					end
					if (m_tdata[267:256] !== e.lrow) begin
						$display("%0t: left_row exp %0d got %0d", $time, e.lrow,
							m_tdata[267:256]);
						errors++;
					end
					if (m_tdata[279:268] !== e.rrow) begin
						$display("%0t: right_row exp %0d got %0d", $time, e.rrow,
							m_tdata[279:268]);
						errors++;
					end
					if (m_tdata[280] !== e.ovf) begin
						$display("%0t: overflowed exp %b got %b", $time, e.ovf, m_tdata[280]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: last_match exp %b got %b", $time, e.last, m_tlast);
						errors++;
					end
				end
			end
			if (m_gap > 0) begin
				m_gap <= m_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				m_gap <= $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("xor_collision_hash_join_top: mismatch");
			$finish;
		end
	end

	task automatic drain();
		while (cmd_queue.size() > 0 || s_tvalid || joins_due.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_key_bits(input int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v[xchj_pkg::KB_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		kb = v;
		key_pool.delete();
	endtask

	task automatic random_mix(input int n);
		int r;
		logic [63:0] key;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if (key_pool.size() > 0 && $urandom_range(0, 1))
					key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else
					key = rand_key();
				if (key_pool.size() < 12) key_pool.insert(key_pool.size(), key);
				else key_pool[$urandom_range(0, 11)] = key;
				push_cmd(xchj_pkg::FUNC_LOAD, make_row(key));
			end else if (r < 88) begin
				r = $urandom_range(0, 99);
				if (key_pool.size() == 0 || r >= 85) key = rand_key();
				else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				// same bucket; a different key only where the flipped bit lies within key_bits
				if (r >= 70 && r < 85) key = key ^ (64'd1 << $urandom_range(10, 63));
				push_cmd(xchj_pkg::FUNC_PROBE, make_row(key));
			end else if (r < 91) begin
				push_cmd(xchj_pkg::FUNC_CLEAR, make_row(rand_key()));
				key_pool.delete();
			end else begin
				push_cmd(FUNC_RSVD, make_row(rand_key()));
			end
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		kb = xchj_pkg::KEY_BITS_RST;
		n_left = 0;
		n_right = 0;
		ovf_flag = 1'b0;
		foreach (bucket_fill[i]) bucket_fill[i] = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, no-match probe, unused code, clear
		push_cmd(xchj_pkg::FUNC_LOAD, '0);
		push_cmd(xchj_pkg::FUNC_LOAD, '1);
		push_cmd(xchj_pkg::FUNC_LOAD, make_row(64'h12345));
		push_cmd(xchj_pkg::FUNC_PROBE, '1);
		push_cmd(xchj_pkg::FUNC_PROBE, '0);
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(64'h12345));
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(64'h12345 ^ 64'h400));
		push_cmd(FUNC_RSVD, '1);
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(64'h12345));
		push_cmd(xchj_pkg::FUNC_CLEAR, '1);
		push_cmd(xchj_pkg::FUNC_PROBE, '0);
		push_cmd(xchj_pkg::FUNC_LOAD, make_row(64'h0));
		push_cmd(xchj_pkg::FUNC_PROBE, '0);

		// zero key width: everything collides, no shift
		set_key_bits(0);
		push_cmd(xchj_pkg::FUNC_CLEAR, '0);
		for (int i = 0; i < 3; i++) push_cmd(xchj_pkg::FUNC_LOAD, make_row(rand_key()));
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(rand_key()));

		// above sixty-four acts as sixty-four
		set_key_bits(127);
		push_cmd(xchj_pkg::FUNC_CLEAR, '0);
		push_cmd(xchj_pkg::FUNC_LOAD, '1);
		push_cmd(xchj_pkg::FUNC_PROBE, '1);

		// one-bit key: full bucket drops loads and sets the sticky flag
		set_key_bits(1);
		push_cmd(xchj_pkg::FUNC_CLEAR, '0);
		for (int i = 0; i < 18; i++) push_cmd(xchj_pkg::FUNC_LOAD, make_row(64'd1));
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(64'd1));
		push_cmd(xchj_pkg::FUNC_PROBE, make_row(64'd0));
		random_mix(40);

		set_key_bits(64);
		push_cmd(xchj_pkg::FUNC_CLEAR, '0);
		random_mix(100);
		set_key_bits(10);
		random_mix(100);
		set_key_bits(3);
		random_mix(60);

		set_key_bits(20);
		quiet = 1'b1;
		push_cmd(xchj_pkg::FUNC_CLEAR, '0);
		random_mix(120);

		while (cmd_queue.size() > 0 || s_tvalid || joins_due.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && joins_due.size() == 0) begin
			$display("xor_collision_hash_join_top: match");
		end else begin
			$display("xor_collision_hash_join_top: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/xchj_pkg.sv
rtl/xchj_ram.sv
rtl/xchj_queue.sv
rtl/xchj_front.sv
rtl/xchj_back.sv
rtl/xor_collision_hash_join_top.sv
rtl/xchj_checker.sv
tb/sv/tb.sv
